// ===== sv/vector2d_alu_macros.svh =====
// Assertion macros shared by the vector ALU.
`ifndef VECTOR2D_ALU_MACROS_SVH
`define VECTOR2D_ALU_MACROS_SVH

// Assert that prop holds on every clock edge outside reset.
`define V2A_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that cons holds in the clock cycle after ante.
`define V2A_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/v2a_pkg.sv =====
// Package with widths, mode codes, pipeline word and CORDIC tables of the vector ALU.
package v2a_pkg;

  localparam int CoordW  = 16;
  localparam int FracBits = 16;
  localparam int VecW    = CoordW + 1;
  localparam int ScalarW = 2 * CoordW + 1;
  localparam int AngleW  = FracBits + 8;
  localparam int MagW    = CoordW + FracBits;
  localparam int Zq      = 32;
  localparam int Iters   = 40;
  localparam int SqW     = 2 * CoordW + 1;
  localparam int RemW    = MagW + 3;
  localparam int Stages  = (Iters > MagW) ? Iters : MagW;
  localparam int StageW  = $clog2(Stages + 1);
  localparam logic [63:0] DegPerRadQ = 64'd246083499208;

  localparam logic [2:0] ModeAdd   = 3'd0;
  localparam logic [2:0] ModeSub   = 3'd1;
  localparam logic [2:0] ModeDot   = 3'd2;
  localparam logic [2:0] ModeCross = 3'd3;
  localparam logic [2:0] ModeAngle = 3'd4;
  localparam logic [2:0] ModeMag   = 3'd5;

  // One item in flight along the cell chain.
  typedef struct packed {
    logic [2:0]         mode;
    logic [VecW-1:0]    vec_x;
    logic [VecW-1:0]    vec_y;
    logic [ScalarW-1:0] scalar;
    logic               undef;
    logic signed [63:0] cx;
    logic signed [63:0] cy;
    logic signed [63:0] cz;
    logic [SqW-1:0]     sq;
    logic [MagW-1:0]    root;
    logic [RemW-1:0]    rem;
  } item_t;

  function automatic logic [63:0] atan_step(input logic [StageW-1:0] i);
    logic [63:0] r;
    unique case (i)
      StageW'(0):  r = 64'd193273528320;
      StageW'(1):  r = 64'd114096026022;
      StageW'(2):  r = 64'd60285206654;
      StageW'(3):  r = 64'd30601712202;
      StageW'(4):  r = 64'd15360239180;
      StageW'(5):  r = 64'd7687607525;
      StageW'(6):  r = 64'd3844741810;
      StageW'(7):  r = 64'd1922488224;
      StageW'(8):  r = 64'd961258780;
      StageW'(9):  r = 64'd480631223;
      StageW'(10): r = 64'd240315841;
      StageW'(11): r = 64'd120157949;
      StageW'(12): r = 64'd60078978;
      default:     r = (DegPerRadQ + (64'd1 << (i - StageW'(1)))) >> i;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/vector2d_alu.sv =====
// Top level of the two-dimensional vector ALU: front stage, cell chain, result stage.
//
// The block takes one item per cycle unless its output stalls, and returns
// one result per item, in order. It has two front stages, one cell per CORDIC
// step or square-root digit (Stages = 40 here) and a result register. The pipeline
// advances as a whole whenever the result register is empty or being taken,
// so in_stall_o is just out_stall_i with a full result register; a stalled
// output holds every stage. Modes 6 and 7 give an all-zero result.
`include "vector2d_alu_macros.svh"

module vector2d_alu (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        mode_i,
  input  logic signed [v2a_pkg::CoordW-1:0] ax_i,
  input  logic signed [v2a_pkg::CoordW-1:0] ay_i,
  input  logic signed [v2a_pkg::CoordW-1:0] bx_i,
  input  logic signed [v2a_pkg::CoordW-1:0] by_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [v2a_pkg::VecW-1:0]   vec_x_o,
  output logic signed [v2a_pkg::VecW-1:0]   vec_y_o,
  output logic signed [v2a_pkg::ScalarW-1:0] scalar_o,
  output logic [v2a_pkg::AngleW-1:0]        angle_deg_o,
  output logic [v2a_pkg::MagW-1:0]          magnitude_o,
  output logic                              undefined_angle_o
);
  localparam int Depth = v2a_pkg::Stages + 2;

  // Valid bits of the front and cell registers, front stages first.
  logic [Depth-1:0] vld_q;
  logic             adv;

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  v2a_pkg::item_t chain [v2a_pkg::Stages+1];

  v2a_front u_front (
    .clk_i  (clk_i),
    .en_i   (adv),
    .mode_i (mode_i),
    .ax_i   (ax_i),
    .ay_i   (ay_i),
    .bx_i   (bx_i),
    .by_i   (by_i),
    .item_o (chain[0])
  );

  for (genvar g = 0; g < v2a_pkg::Stages; g++) begin : g_cell
    v2a_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .idx_i  (v2a_pkg::StageW'(g)),
      .item_i (chain[g]),
      .item_o (chain[g+1])
    );
  end

  // Result stage: clamp and round the angle, round the root, gate by mode.
  v2a_pkg::item_t   last;
  logic signed [63:0] z;
  logic [63:0]      zr;
  logic [v2a_pkg::MagW-1:0] root;
  logic [v2a_pkg::AngleW-1:0] ang_d;
  logic [v2a_pkg::MagW-1:0]   mag_d;
  logic out_valid_q;

  always_comb begin
    last = chain[v2a_pkg::Stages];
    z = last.cz;
    if (z < 0) z = '0;
    if (z > (64'sd180 <<< v2a_pkg::Zq)) z = 64'sd180 <<< v2a_pkg::Zq;
    zr = (unsigned'(z) + (64'd1 << (v2a_pkg::Zq - 1 - v2a_pkg::FracBits)))
         >> (v2a_pkg::Zq - v2a_pkg::FracBits);
    root = last.root;
    if (last.rem > v2a_pkg::RemW'(root)) root = root + v2a_pkg::MagW'(1);
    ang_d = ((last.mode == v2a_pkg::ModeAngle) && !last.undef)
            ? v2a_pkg::AngleW'(zr) : '0;
    mag_d = (last.mode == v2a_pkg::ModeMag) ? root : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vec_x_o           <= signed'(last.vec_x);
      vec_y_o           <= signed'(last.vec_y);
      scalar_o          <= signed'(last.scalar);
      angle_deg_o       <= ang_d;
      magnitude_o       <= mag_d;
      undefined_angle_o <= last.undef;
    end
  end

  assign out_valid_o = out_valid_q;

  // A stalled result holds and stays valid.
  `V2A_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(magnitude_o), "result dropped under stall")
  // Only angle mode raises the zero-vector flag, and then the angle is zero.
  `V2A_ASSERT(a_undef, !(out_valid_o && undefined_angle_o) || (angle_deg_o == '0), "angle with flag")
  // The input is stalled only while a result is held.
  `V2A_ASSERT(a_stall, !in_stall_o || (out_valid_o && out_stall_i), "spurious input stall")
endmodule

// ===== sv/v2a_front.sv =====
// Entry stage: products, sum and difference, CORDIC pre-rotation and normalization.
module v2a_front (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [2:0]                      mode_i,
  input  logic signed [v2a_pkg::CoordW-1:0] ax_i,
  input  logic signed [v2a_pkg::CoordW-1:0] ay_i,
  input  logic signed [v2a_pkg::CoordW-1:0] bx_i,
  input  logic signed [v2a_pkg::CoordW-1:0] by_i,
  output v2a_pkg::item_t                  item_o
);
  localparam int PW = 2 * v2a_pkg::CoordW;

  // Stage one: register the products.
  logic [2:0] mode_q;
  logic signed [v2a_pkg::CoordW-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [PW-1:0] axbx_q, ayby_q, axby_q, aybx_q, axax_q, ayay_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_q <= mode_i;
      ax_q <= ax_i; ay_q <= ay_i; bx_q <= bx_i; by_q <= by_i;
      axbx_q <= ax_i * bx_i;
      ayby_q <= ay_i * by_i;
      axby_q <= ax_i * by_i;
      aybx_q <= ay_i * bx_i;
      axax_q <= ax_i * ax_i;
      ayay_q <= ay_i * ay_i;
    end
  end

  // Stage two: sums, pre-rotation, normalization.
  logic signed [v2a_pkg::ScalarW-1:0] dot, cross_z;
  logic [v2a_pkg::ScalarW-1:0] cabs;
  logic [63:0] nx, ny, m;
  logic [6:0] len;
  v2a_pkg::item_t d;

  always_comb begin
    dot     = v2a_pkg::ScalarW'(axbx_q) + v2a_pkg::ScalarW'(ayby_q);
    cross_z = v2a_pkg::ScalarW'(axby_q) - v2a_pkg::ScalarW'(aybx_q);
    cabs    = cross_z[v2a_pkg::ScalarW-1] ? v2a_pkg::ScalarW'(-cross_z)
                                          : v2a_pkg::ScalarW'(cross_z);
    d = '0;
    d.mode = mode_q;
    if (dot[v2a_pkg::ScalarW-1]) begin
      nx = 64'(cabs);
      ny = 64'(v2a_pkg::ScalarW'(-dot));
      d.cz = 64'sd90 <<< v2a_pkg::Zq;
    end else begin
      nx = 64'(unsigned'(dot));
      ny = 64'(cabs);
    end
    m = nx | ny;
    len = 7'd0;
    for (int k = 0; k < 64; k++) begin
      if (m[k]) len = 7'(k + 1);
    end
    // Values are at most 33 bits wide, so only a left shift is needed.
    d.cx = signed'(nx << (7'd60 - len));
    d.cy = signed'(ny << (7'd60 - len));
    unique case (mode_q)
      v2a_pkg::ModeAdd: begin
        d.vec_x = v2a_pkg::VecW'(ax_q) + v2a_pkg::VecW'(bx_q);
        d.vec_y = v2a_pkg::VecW'(ay_q) + v2a_pkg::VecW'(by_q);
      end
      v2a_pkg::ModeSub: begin
        d.vec_x = v2a_pkg::VecW'(ax_q) - v2a_pkg::VecW'(bx_q);
        d.vec_y = v2a_pkg::VecW'(ay_q) - v2a_pkg::VecW'(by_q);
      end
      v2a_pkg::ModeDot:   d.scalar = unsigned'(dot);
      v2a_pkg::ModeCross: d.scalar = unsigned'(cross_z);
      v2a_pkg::ModeAngle: d.undef = ((ax_q == '0) && (ay_q == '0)) ||
                                    ((bx_q == '0) && (by_q == '0));
      default: ;
    endcase
    d.sq = v2a_pkg::SqW'(unsigned'(axax_q)) + v2a_pkg::SqW'(unsigned'(ayay_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) item_o <= d;
  end
endmodule

// ===== sv/v2a_cell.sv =====
// One chain cell: a CORDIC vectoring step while steps remain and a square-root digit while digits remain.
module v2a_cell (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [v2a_pkg::StageW-1:0]        idx_i,
  input  v2a_pkg::item_t                    item_i,
  output v2a_pkg::item_t                    item_o
);
  v2a_pkg::item_t d;
  logic signed [63:0] dx, dy, t;
  logic [1:0] pair;
  logic [v2a_pkg::RemW-1:0] rem, trial;
  int k, sh;

  always_comb begin
    d = item_i;
    // CORDIC step, only while steps remain.
    if (idx_i < v2a_pkg::StageW'(v2a_pkg::Iters)) begin
      dx = item_i.cy >>> idx_i;
      dy = item_i.cx >>> idx_i;
      t  = signed'(v2a_pkg::atan_step(idx_i));
      if (!item_i.cy[63]) begin
        d.cx = item_i.cx + dx; d.cy = item_i.cy - dy; d.cz = item_i.cz + t;
      end else begin
        d.cx = item_i.cx - dx; d.cy = item_i.cy + dy; d.cz = item_i.cz - t;
      end
    end else begin
      dx = '0; dy = '0; t = '0;
    end
    // Square-root digit k = MagW-1-idx.
    k = v2a_pkg::MagW - 1 - int'(idx_i);
    pair = 2'b00;
    rem = item_i.rem;
    trial = '0;
    sh = 0;
    if (k >= 0) begin
      if (k >= v2a_pkg::FracBits) begin
        sh = 2 * (k - v2a_pkg::FracBits);
        pair = 2'(item_i.sq >> sh);
      end
      rem = {item_i.rem[v2a_pkg::RemW-3:0], pair};
      trial = v2a_pkg::RemW'({item_i.root, 2'b01});
      if (rem >= trial) begin
        d.rem = rem - trial;
        d.root = {item_i.root[v2a_pkg::MagW-2:0], 1'b1};
      end else begin
        d.rem = rem;
        d.root = {item_i.root[v2a_pkg::MagW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) item_o <= d;
  end
endmodule
